// ----- rtl/fibmp_pkg.sv -----
package fibmp_pkg;

   // Width of the Fibonacci index field.
   localparam int unsigned INDEX_BITS = 63;
   // Width of the bit counter that walks the index during the division.
   localparam int unsigned BIT_CNT_BITS = $clog2(INDEX_BITS);

   typedef logic [2:0] state_type;

   localparam state_type ST_IDLE   = 3'd0;
   localparam state_type ST_PERIOD = 3'd1;
   localparam state_type ST_DIV    = 3'd2;
   localparam state_type ST_STEP   = 3'd3;
   localparam state_type ST_DONE   = 3'd4;

endpackage

// ----- rtl/fibonacci_mod_pisano.sv -----
// fibonacci_mod_pisano: returns F(n) mod m for a 63-bit index n and a modulus m.
//
// Request channel (req_valid / req_stall / req_index_n / req_modulus): an item
// is taken when req_valid is high and req_stall is low. req_stall stays high
// while an item is being worked on; the block handles one item at a time.
// Response channel (rsp_valid / rsp_stall / rsp_residue): one item per request,
// held in an output register until the receiver takes it with rsp_stall low.
// The next request is taken while that response still waits.
//
// Sequence: a modulus below two or an index below two skips straight to loading
// the output register. Otherwise the block runs the Pisano period search (P <= 6m),
// the restoring division of n by P (one index bit a cycle), the stepping to
// r = n mod P and the loading of the output register. The single modular adder
// that steps the pair sets the pace of the search and the stepping. A finished
// result that finds the output register still occupied waits in place until
// the receiver drains it.
//
// Reset (synchronous, active high) returns the sequencer to idle and empties
// the output register; no query state survives between items.
module fibonacci_mod_pisano #(
   parameter int unsigned MOD_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [fibmp_pkg::INDEX_BITS-1:0]      req_index_n,
   input  logic [MOD_BITS-1:0]                   req_modulus,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [MOD_BITS-1:0]                   rsp_residue
);

   // The Pisano period never exceeds 6m, so three bits above the modulus suffice.
   localparam int unsigned PER_BITS = MOD_BITS + 3;
   localparam int unsigned BC = fibmp_pkg::BIT_CNT_BITS;
   localparam int unsigned NB = fibmp_pkg::INDEX_BITS;

   fibmp_pkg::state_type          state_ff, state_in;
   logic [NB-1:0]                 index_ff, index_in;
   logic [MOD_BITS-1:0]           mod_ff, mod_in;
   logic [MOD_BITS-1:0]           prev_ff, prev_in;
   logic [MOD_BITS-1:0]           curr_ff, curr_in;
   logic [PER_BITS-1:0]           cnt_ff, cnt_in;
   logic [PER_BITS-1:0]           rem_ff, rem_in;
   logic [BC-1:0]                 bit_ff, bit_in;
   logic [MOD_BITS-1:0]           result_ff, result_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [MOD_BITS-1:0]           rsp_residue_ff, rsp_residue_in;

   // Shared modular adder: (prev + curr) mod m with one conditional subtract.
   logic [MOD_BITS:0]             sum;
   logic [MOD_BITS-1:0]           next_res;
   // Restoring division step.
   logic [PER_BITS:0]             trial;
   logic [PER_BITS:0]             trial_sub;
   logic                          trial_ge;
   logic                          req_take;
   logic                          slot_free;

   assign sum      = {1'b0, prev_ff} + {1'b0, curr_ff};
   assign next_res = (sum >= {1'b0, mod_ff}) ? MOD_BITS'(sum - {1'b0, mod_ff})
                                             : sum[MOD_BITS-1:0];

   assign trial     = {rem_ff, index_ff[NB-1]};
   assign trial_ge  = trial >= {1'b0, cnt_ff};
   assign trial_sub = trial - {1'b0, cnt_ff};

   assign req_stall = (state_ff != fibmp_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      index_in       = index_ff;
      mod_in         = mod_ff;
      prev_in        = prev_ff;
      curr_in        = curr_ff;
      cnt_in         = cnt_ff;
      rem_in         = rem_ff;
      bit_in         = bit_ff;
      result_in      = result_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_residue_in = rsp_residue_ff;

      unique case (state_ff)
         fibmp_pkg::ST_IDLE: begin
            if (req_take) begin
               index_in = req_index_n;
               mod_in   = req_modulus;
               prev_in  = '0;
               curr_in  = MOD_BITS'(1);
               cnt_in   = '0;
               rem_in   = '0;
               bit_in   = BC'(NB - 1);
               if (req_modulus < MOD_BITS'(2)) begin
                  // Modulus zero or one: every residue is zero.
                  result_in = '0;
                  state_in  = fibmp_pkg::ST_DONE;
               end else if (req_index_n < NB'(2)) begin
                  // F(0) = 0 and F(1) = 1 need no stepping.
                  result_in = MOD_BITS'(req_index_n[0]);
                  state_in  = fibmp_pkg::ST_DONE;
               end else begin
                  state_in = fibmp_pkg::ST_PERIOD;
               end
            end
         end
         fibmp_pkg::ST_PERIOD: begin
            // Advance the pair and count until (0, 1) comes back.
            prev_in = curr_ff;
            curr_in = next_res;
            cnt_in  = cnt_ff + PER_BITS'(1);
            if (curr_ff == '0 && next_res == MOD_BITS'(1)) begin
               state_in = fibmp_pkg::ST_DIV;
            end
         end
         fibmp_pkg::ST_DIV: begin
            // One index bit a cycle, MSB first; remainder stays below the period.
            index_in = {index_ff[NB-2:0], 1'b0};
            rem_in   = trial_ge ? trial_sub[PER_BITS-1:0] : trial[PER_BITS-1:0];
            bit_in   = bit_ff - BC'(1);
            if (bit_ff == '0) begin
               cnt_in   = trial_ge ? trial_sub[PER_BITS-1:0] : trial[PER_BITS-1:0];
               prev_in  = '0;
               curr_in  = MOD_BITS'(1);
               state_in = fibmp_pkg::ST_STEP;
            end
         end
         fibmp_pkg::ST_STEP: begin
            // Step the pair from (F(0), F(1)) up to the reduced index.
            if (cnt_ff == '0) begin
               result_in = prev_ff;
               state_in  = fibmp_pkg::ST_DONE;
            end else begin
               prev_in = curr_ff;
               curr_in = next_res;
               cnt_in  = cnt_ff - PER_BITS'(1);
            end
         end
         fibmp_pkg::ST_DONE: begin
            // Hold the result until the output register can take it.
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_residue_in = result_ff;
               state_in       = fibmp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fibmp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fibmp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff       <= index_in;
      mod_ff         <= mod_in;
      prev_ff        <= prev_in;
      curr_ff        <= curr_in;
      cnt_ff         <= cnt_in;
      rem_ff         <= rem_in;
      bit_ff         <= bit_in;
      result_ff      <= result_in;
      rsp_residue_ff <= rsp_residue_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_residue = rsp_residue_ff;

endmodule

// ----- tb/fibonacci_mod_pisano_test.sv -----
module fibonacci_mod_pisano_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned INDEX_BITS = fibmp_pkg::INDEX_BITS;

   localparam int unsigned MOD_BITS = 16;

   // Watchdog. The limit covers the slowest legal run here: a handful of
   // full-range moduli, about a dozen mid-size ones, and both sides idling
   // between items.
   localparam longint unsigned CYCLE_LIMIT = 20_000_000;
   // Receiver hold-off while the sender floods short queries.
   localparam int unsigned LONG_HOLD_CYCLES = 600;
   // Extra cycles after the last expected residue, to catch a stray item.
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned NUM_DIRECTED = 20;
   localparam int unsigned NUM_RANDOM = 80;
   // The first random queries go back to back on tiny moduli during the hold-off.
   localparam int unsigned NUM_FLOOD = 12;

   localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};
   localparam logic [MOD_BITS-1:0] MODULUS_MAX = {MOD_BITS{1'b1}};

   // One query as the scoreboard keeps it: what went in and the residue due.
   typedef struct {
      logic [INDEX_BITS-1:0] index_n;
      logic [MOD_BITS-1:0]   modulus;
      logic [MOD_BITS-1:0]   residue;
   } pending_query_type;

   // One row of the directed table. has_residue marks rows whose answer is
   // obvious; the others take their answer from fib_residue.
   typedef struct packed {
      logic [INDEX_BITS-1:0] index_n;
      logic [MOD_BITS-1:0]   modulus;
      logic                  has_residue;
      logic [MOD_BITS-1:0]   residue;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [INDEX_BITS-1:0] req_index_n = '0;
   logic [MOD_BITS-1:0]   req_modulus = MOD_BITS'(2);
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [MOD_BITS-1:0]   rsp_residue;

   // The receiver's per-item wait and the long hold-off come from separate
   // processes; either one holds the result channel.
   logic rsp_hold_item = 1'b1;
   logic rsp_hold_long = 1'b0;
   assign rsp_stall = rsp_hold_item | rsp_hold_long;

   // Raised by the sender when the flood of short queries starts.
   logic flood_go = 1'b0;

   pending_query_type residue_q[$];
   int unsigned       fail_count = 0;
   int unsigned       sent_count = 0;
   int unsigned       taken_count = 0;

   fibonacci_mod_pisano #(
      .MOD_BITS(MOD_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_index_n(req_index_n),
      .req_modulus(req_modulus),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_residue(rsp_residue)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Residue of F(n) modulo m. Find the Pisano period by stepping the pair
   // (F(k), F(k+1)) mod m from (0, 1) until (0, 1) returns, reduce n by it,
   // then step again from (0, 1) to the reduced index.
   function automatic logic [MOD_BITS-1:0] fib_residue(input logic [INDEX_BITS-1:0] n,
                                                       input logic [MOD_BITS-1:0] m);
      int unsigned       lo;
      int unsigned       hi;
      int unsigned       nx;
      int unsigned       m_val;
      longint unsigned   period;
      longint unsigned   steps;
      longint unsigned   k;
      // Modulus zero or one: everything reduces to zero.
      if (m < 2) return '0;
      // Index zero or one: F(n) = n, already below any m of two or more.
      if (n < 2) return MOD_BITS'(n);
      m_val = 32'(m);
      lo = 0;
      hi = 1;
      period = 0;
      forever begin
         nx = (lo + hi) % m_val;
         lo = hi;
         hi = nx;
         period++;
         if (lo == 0 && hi == 1) break;
      end
      steps = 64'(n) % period;
      lo = 0;
      hi = 1;
      for (k = 0; k < steps; k++) begin
         nx = (lo + hi) % m_val;
         lo = hi;
         hi = nx;
      end
      return lo[MOD_BITS-1:0];
   endfunction

   // Idle cycles before the next item. Six items out of every 24 take none,
   // so that runs of full throughput show up on both sides.
   function automatic int unsigned draw_wait(input int unsigned k);
      if (k % 24 < 6) return 0;
      return $urandom_range(0, 17);
   endfunction

   // Offer one query and hold it until the block takes it, then file the
   // residue it should produce. Entered and left at a rising edge.
   task automatic offer_query(input logic [INDEX_BITS-1:0] n,
                              input logic [MOD_BITS-1:0] m,
                              input logic has_residue,
                              input logic [MOD_BITS-1:0] residue,
                              input bit back_to_back);
      int unsigned       gap;
      pending_query_type q;
      gap = back_to_back ? 0 : draw_wait(sent_count);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // valid stays high straight into the next item when there is no gap
      req_valid <= 1'b1;
      req_index_n <= n;
      req_modulus <= m;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      q.index_n = n;
      q.modulus = m;
      q.residue = has_residue ? residue : fib_residue(n, m);
      residue_q = {residue_q, q};
      sent_count++;
   endtask

   // Stimulus: directed table first, then random queries, then drain.
   initial begin : stimulus
      directed_row_type       rows [NUM_DIRECTED];
      logic [63:0]            raw64;
      logic [INDEX_BITS-1:0]  n;
      logic [MOD_BITS-1:0]    m;
      int unsigned            sel;
      int unsigned            i;

      rows = '{
         // index zero and one: the residue is the index itself
         '{63'd0,     16'd2,       1'b1, 16'd0},
         '{63'd1,     16'd2,       1'b1, 16'd1},
         '{63'd0,     MODULUS_MAX, 1'b1, 16'd0},
         '{63'd1,     MODULUS_MAX, 1'b1, 16'd1},
         '{63'd1,     16'd4,       1'b1, 16'd1},
         // first index past the short cut, and a small index with a known residue
         '{63'd2,     16'd2,       1'b1, 16'd1},
         '{63'd2,     MODULUS_MAX, 1'b1, 16'd1},
         '{63'd10,    16'd1000,    1'b1, 16'd55},
         // modulus zero and one: residue is zero whatever the index
         '{INDEX_MAX, 16'd0,       1'b1, 16'd0},
         '{63'd5,     16'd0,       1'b1, 16'd0},
         '{INDEX_MAX, 16'd1,       1'b1, 16'd0},
         // index a multiple of the period, and one past it
         '{63'd3,     16'd2,       1'b0, 16'd0},
         '{63'd8,     16'd3,       1'b0, 16'd0},
         '{63'd9,     16'd3,       1'b0, 16'd0},
         '{63'd60,    16'd10,      1'b0, 16'd0},
         '{63'd61,    16'd10,      1'b0, 16'd0},
         // largest index against small and composite moduli, a patterned index against a large prime
         '{INDEX_MAX, 16'd2,       1'b0, 16'd0},
         '{INDEX_MAX, 16'd3,       1'b0, 16'd0},
         '{INDEX_MAX, 16'd65534,   1'b0, 16'd0},
         '{63'h5555_5555_5555_5555, 16'd65521, 1'b0, 16'd0}
      };

      while (reset) @(posedge clock);

      for (i = 0; i < NUM_DIRECTED; i++) begin
         offer_query(rows[i].index_n, rows[i].modulus, rows[i].has_residue,
                     rows[i].residue, 1'b0);
      end

      // Drop valid and let the last long directed query finish, so the
      // hold-off below meets an idle block.
      req_valid <= 1'b0;
      while (residue_q.size() != 0) @(posedge clock);

      // Kick off the receiver hold-off, then flood it with short queries.
      flood_go <= 1'b1;
      for (i = 0; i < NUM_RANDOM; i++) begin
         raw64 = {$urandom, $urandom};
         n = raw64[INDEX_BITS-1:0];
         if (i < NUM_FLOOD) begin
            m = MOD_BITS'($urandom_range(2, 12));
         end else begin
            // mostly small moduli to keep the run short, a few mid-size, one
            // in 33 over the whole range, and now and then zero or one
            sel = $urandom_range(0, 99);
            if (i % 33 == 32) m = MOD_BITS'($urandom_range(2, 65535));
            else if (sel < 2) m = MOD_BITS'($urandom_range(0, 1));
            else if (sel < 17) m = MOD_BITS'($urandom_range(256, 4095));
            else m = MOD_BITS'($urandom_range(2, 255));
            // one draw in eight gives an index up to three, often on the short cut, one in eight up to 1000
            sel = $urandom_range(0, 7);
            if (sel == 0) n = INDEX_BITS'($urandom_range(0, 3));
            else if (sel == 1) n = INDEX_BITS'($urandom_range(0, 1000));
         end
         offer_query(n, m, 1'b0, '0, i < NUM_FLOOD);
      end
      req_valid <= 1'b0;

      // Wait out every residue, then a little longer for anything stray.
      while (residue_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && residue_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Receiver: idle a random number of cycles per item, then take the next
   // residue and compare it with the oldest pending query.
   initial begin : residue_check
      int unsigned       hold;
      pending_query_type q;
      while (reset) @(posedge clock);
      forever begin
         hold = draw_wait(taken_count + 11);
         if (hold > 0) begin
            rsp_hold_item <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_hold_item <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         taken_count++;
         if (residue_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("residue %0d arrived with no query pending", rsp_residue);
         end else begin
            q = residue_q.pop_front();
            if (rsp_residue !== q.residue) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("residue for n=%0d m=%0d: expected %0d, got %0d",
                           q.index_n, q.modulus, q.residue, rsp_residue);
            end
         end
      end
   end

   // Long hold-off: block the result channel for a fixed stretch once the
   // flood starts, so the output register fills and the block stalls its input.
   initial begin : long_hold
      while (!flood_go) @(posedge clock);
      rsp_hold_long <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      rsp_hold_long <= 1'b0;
   end

   // Reset once at the start.
   initial begin : reset_seq
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog: end the run if it hangs.
   initial begin : watchdog
      longint unsigned cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d residues pending", cycles,
                     residue_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

endmodule
